/* sv/lpht_pkg.sv */
package lpht_pkg;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_DUP       = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic clr;        // clearing pass write
        logic load;       // latch request beat
        logic hash_step;  // fold one key byte into the hash
        logic mul1;       // hash * reciprocal
        logic mul2;       // quotient * table size
        logic modr;       // remainder correction, home slot
        logic rd_home;    // read the home slot
        logic probe;      // evaluate the slot just read
        logic wr_a;       // first write-back
        logic wr_b;       // second write-back (home slot)
        logic out_load;   // move result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic hash_done;
        logic probe_stop;
        logic out_free;
    } stat_t;

    // drop everything after the first zero byte
    function automatic logic [63:0] clip_key(input logic [63:0] k);
        logic [63:0] r;
        logic        live;
        r    = '0;
        live = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (k[63 - 8*b -: 8] == 8'h00)
                live = 1'b0;
            if (live)
                r[63 - 8*b -: 8] = k[63 - 8*b -: 8];
        end
        return r;
    endfunction

    function automatic logic [63:0] fold_key(input logic [63:0] k);
        logic [63:0] r;
        logic [7:0]  c;
        r = '0;
        for (int b = 0; b < 8; b++) begin
            c = k[8*b +: 8];
            if (c inside {[8'h41:8'h5A]})
                c = c + 8'd32;
            r[8*b +: 8] = c;
        end
        return r;
    endfunction

    function automatic logic keys_equal(input logic [63:0] a, input logic [63:0] b,
                                        input logic ci);
        logic eq;
        if (ci)
            eq = (fold_key(a) == fold_key(b));
        else
            eq = (a == b);
        return eq;
    endfunction

endpackage

/* sv/lpht_if.sv */
interface lpht_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] key;
    logic [31:0] entry_value;

    modport source (output valid, output req_type, output key, output entry_value,
                    input ready);
    modport sink   (input valid, input req_type, input key, input entry_value,
                    output ready);
endinterface

interface lpht_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [7:0]  slot;

    modport source (output valid, output status, output found_value, output slot,
                    input ready);
    modport sink   (input valid, input status, input found_value, input slot,
                    output ready);
endinterface

/* sv/linear_probe_hash_table.sv */
// channel | dir | beat contents                       | handshake
// req     | in  | req_type, key, entry_value          | valid/ready
// rsp     | out | status, found_value, slot           | valid/ready
// cfg     | in  | cfg_wdata (case_insensitive)        | cfg_we, no stall
//
// One request at a time. A beat is accepted, the key is hashed a byte at a
// time until HASH_LEN bytes or a zero byte end it, a reciprocal mod gives the
// home slot, the home slot is read, the probed slots are read in turn, a
// first and a second write-back follow, and the result is loaded.
// The probe loop is bound by the single read port of the slot memory.
// After reset a clearing pass marks every slot empty; req.ready stays low
// during it. A new request beat is taken while the previous result still
// waits on a stalled rsp channel.
module linear_probe_hash_table #(
    parameter int TABLE_SIZE = 251,
    parameter int HASH_LEN   = 8,
    parameter int MAX_PROBE  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    lpht_req_if.sink   req,
    lpht_rsp_if.source rsp,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);
    import lpht_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: clear pass, hash, mod, probe, write-back, result
    lpht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // slot memory, hash unit, compare and output register
    lpht_dp #(
        .TABLE_SIZE (TABLE_SIZE),
        .HASH_LEN   (HASH_LEN),
        .MAX_PROBE  (MAX_PROBE)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_req_type     (req.req_type),
        .in_key          (req.key),
        .in_entry_value  (req.entry_value),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .out_status      (rsp.status),
        .out_found_value (rsp.found_value),
        .out_slot        (rsp.slot)
    );

endmodule

/* sv/lpht_ctrl.sv */
module lpht_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lpht_pkg::stat_t stat,
    output lpht_pkg::cmd_t  cmd
);
    import lpht_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_HASH  = 4'd2;
    localparam logic [3:0] ST_MUL1  = 4'd3;
    localparam logic [3:0] ST_MUL2  = 4'd4;
    localparam logic [3:0] ST_MOD   = 4'd5;
    localparam logic [3:0] ST_RDH   = 4'd6;
    localparam logic [3:0] ST_PROBE = 4'd7;
    localparam logic [3:0] ST_WRA   = 4'd8;
    localparam logic [3:0] ST_WRB   = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (stat.hash_done)
                    state_next = ST_MUL1;
                else
                    cmd.hash_step = 1'b1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.modr   = 1'b1;
                state_next = ST_RDH;
            end
            ST_RDH:
            begin
                cmd.rd_home = 1'b1;
                state_next  = ST_PROBE;
            end
            ST_PROBE:
            begin
                cmd.probe = 1'b1;
                if (stat.probe_stop)
                    state_next = ST_WRA;
            end
            ST_WRA:
            begin
                cmd.wr_a   = 1'b1;
                state_next = ST_WRB;
            end
            ST_WRB:
            begin
                cmd.wr_b   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/lpht_dp.sv */
module lpht_dp #(
    parameter int TABLE_SIZE = 251,
    parameter int HASH_LEN   = 8,
    parameter int MAX_PROBE  = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  lpht_pkg::cmd_t  cmd,
    output lpht_pkg::stat_t stat,
    input  logic [1:0]      in_req_type,
    input  logic [63:0]     in_key,
    input  logic [31:0]     in_entry_value,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [1:0]      out_status,
    output logic [31:0]     out_found_value,
    output logic [7:0]      out_slot
);
    import lpht_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int DW = IW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);
    localparam logic [DW-1:0] LAST_DEV = DW'(TABLE_SIZE - 1);
    localparam logic [31:0]   TS32     = 32'(TABLE_SIZE);
    localparam logic [63:0]   RECIP_W  = 64'h1_0000_0000 / 64'(TABLE_SIZE);
    localparam logic [31:0]   RECIP    = RECIP_W[31:0];

    // table storage
    logic        mem_valid [TABLE_SIZE];
    logic [63:0] mem_key   [TABLE_SIZE];
    logic [31:0] mem_val   [TABLE_SIZE];

    logic          rq_valid;
    logic [63:0]   rq_key;
    logic [31:0]   rq_val;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          wr_vld;
    logic [63:0]   wr_key;
    logic [31:0]   wr_val;

    // request and working registers
    logic [1:0]    req_reg;
    logic [63:0]   key_reg;
    logic [31:0]   val_reg;
    logic [63:0]   hkey_reg;
    logic [3:0]    hk_reg;
    logic [31:0]   h_reg;
    logic [63:0]   prod_reg;
    logic [31:0]   qts_reg;
    logic [IW-1:0] home_reg;
    logic [IW-1:0] idx_reg;
    logic [DW-1:0] dev_reg;
    logic [63:0]   hent_key_reg;
    logic [31:0]   hent_val_reg;
    logic [7:0]    maxdev_reg;
    logic          ci_reg;

    // write-back plan
    logic          wa_en_reg;
    logic [IW-1:0] wa_addr_reg;
    logic [63:0]   wa_key_reg;
    logic [31:0]   wa_val_reg;
    logic          wb_en_reg;
    logic          wb_vld_reg;
    logic [63:0]   wb_key_reg;
    logic [31:0]   wb_val_reg;

    // result
    logic [1:0]    res_status_reg;
    logic [31:0]   res_found_reg;
    logic [7:0]    res_slot_reg;
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [31:0]   out_found_reg;
    logic [7:0]    out_slot_reg;

    // probe decision
    logic          p_stop;
    logic          p_adv;
    logic          p_eq;
    logic [1:0]    p_status;
    logic [31:0]   p_found;
    logic [7:0]    p_slot;
    logic          p_wa_en;
    logic [63:0]   p_wa_key;
    logic [31:0]   p_wa_val;
    logic          p_wb_en;
    logic          p_wb_vld;
    logic          p_maxdev_en;
    logic [IW-1:0] nxt_idx;
    logic [31:0]   mod_diff;
    logic [31:0]   hash_xor;

    assign nxt_idx  = (idx_reg == LAST_IDX) ? '0 : idx_reg + IW'(1);
    assign mod_diff = h_reg - qts_reg;
    assign hash_xor = 32'(HASH_LEN - 1) - 32'(hk_reg);
    assign p_eq     = keys_equal(rq_key, key_reg, ci_reg);

    assign stat.clr_last   = (idx_reg == LAST_IDX);
    assign stat.hash_done  = (hk_reg == 4'(HASH_LEN)) || (hkey_reg[63:56] == 8'h00);
    assign stat.probe_stop = p_stop;
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        p_stop      = 1'b0;
        p_adv       = 1'b0;
        p_status    = STATUS_NOT_FOUND;
        p_found     = '0;
        p_slot      = 8'(home_reg);
        p_wa_en     = 1'b0;
        p_wa_key    = key_reg;
        p_wa_val    = val_reg;
        p_wb_en     = 1'b0;
        p_wb_vld    = 1'b1;
        p_maxdev_en = 1'b0;
        case (req_reg)
            REQ_INSERT:
            begin
                if (!rq_valid)
                begin
                    p_stop = 1'b1;
                    if (32'(dev_reg) > 32'(MAX_PROBE))
                        p_status = STATUS_FULL;
                    else
                    begin
                        p_status    = STATUS_OK;
                        p_slot      = 8'(idx_reg);
                        p_wa_en     = 1'b1;
                        p_maxdev_en = (32'(dev_reg) > 32'(maxdev_reg));
                    end
                end
                else if (dev_reg == LAST_DEV)
                begin
                    p_stop   = 1'b1;
                    p_status = STATUS_FULL;
                end
                else if (p_eq)
                begin
                    p_stop   = 1'b1;
                    p_status = STATUS_DUP;
                    p_slot   = 8'(idx_reg);
                end
                else
                    p_adv = 1'b1;
            end
            REQ_LOOKUP, REQ_REMOVE:
            begin
                if (rq_valid && p_eq)
                begin
                    p_stop   = 1'b1;
                    p_status = STATUS_OK;
                    // home entry moves to the found slot; lookup swaps the found entry into home, remove clears home
                    p_wa_en  = (idx_reg != home_reg);
                    p_wa_key = hent_key_reg;
                    p_wa_val = hent_val_reg;
                    if (req_reg == REQ_LOOKUP)
                    begin
                        p_found = rq_val;
                        p_wb_en = (idx_reg != home_reg);
                    end
                    else
                    begin
                        p_wb_en  = 1'b1;
                        p_wb_vld = 1'b0;
                    end
                end
                else if (!rq_valid)
                    p_stop = 1'b1;
                else if (32'(dev_reg) + 32'd1 > 32'(maxdev_reg))
                    p_stop = 1'b1;
                else
                    p_adv = 1'b1;
            end
            default:
            begin
                p_stop = 1'b1;
                p_slot = '0;
            end
        endcase
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = home_reg;
        if (cmd.rd_home)
            rd_en = 1'b1;
        else if (cmd.probe && p_adv)
        begin
            rd_en   = 1'b1;
            rd_addr = nxt_idx;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_vld  = 1'b0;
        wr_key  = wa_key_reg;
        wr_val  = wa_val_reg;
        if (cmd.clr)
            wr_en = 1'b1;
        else if (cmd.wr_a)
        begin
            wr_en   = wa_en_reg;
            wr_addr = wa_addr_reg;
            wr_vld  = 1'b1;
        end
        else if (cmd.wr_b)
        begin
            wr_en   = wb_en_reg;
            wr_addr = home_reg;
            wr_vld  = wb_vld_reg;
            wr_key  = wb_key_reg;
            wr_val  = wb_val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_valid[wr_addr] <= wr_vld;
            mem_key[wr_addr]   <= wr_key;
            mem_val[wr_addr]   <= wr_val;
        end
        if (rd_en)
        begin
            rq_valid <= mem_valid[rd_addr];
            rq_key   <= mem_key[rd_addr];
            rq_val   <= mem_val[rd_addr];
        end
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            maxdev_reg    <= '0;
            ci_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            wa_en_reg     <= 1'b0;
            wb_en_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ci_reg <= cfg_wdata;
            if (cmd.clr)
                idx_reg <= nxt_idx;
            else if (cmd.rd_home)
                idx_reg <= home_reg;
            else if (cmd.probe && p_adv)
                idx_reg <= nxt_idx;
            if (cmd.probe && p_stop)
            begin
                wa_en_reg <= p_wa_en;
                wb_en_reg <= p_wb_en;
                if (p_maxdev_en)
                    maxdev_reg <= 8'(dev_reg);
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= in_req_type;
            key_reg  <= clip_key(in_key);
            hkey_reg <= clip_key(in_key);
            val_reg  <= in_entry_value;
            h_reg    <= '0;
            hk_reg   <= '0;
        end
        if (cmd.hash_step)
        begin
            h_reg    <= (((h_reg << 1) + 32'd3) ^ hash_xor) + 32'(hkey_reg[63:56]);
            hk_reg   <= hk_reg + 4'd1;
            hkey_reg <= {hkey_reg[55:0], 8'h00};
        end
        if (cmd.mul1)
            prod_reg <= 64'(h_reg) * 64'(RECIP);
        if (cmd.mul2)
            qts_reg <= 32'(prod_reg[63:32] * TS32);
        if (cmd.modr)
            home_reg <= IW'((mod_diff >= TS32) ? mod_diff - TS32 : mod_diff);
        if (cmd.rd_home)
            dev_reg <= '0;
        else if (cmd.probe && p_adv)
            dev_reg <= dev_reg + DW'(1);
        if (cmd.probe && dev_reg == '0)
        begin
            hent_key_reg <= rq_key;
            hent_val_reg <= rq_val;
        end
        if (cmd.probe && p_stop)
        begin
            wa_addr_reg    <= idx_reg;
            wa_key_reg     <= p_wa_key;
            wa_val_reg     <= p_wa_val;
            wb_vld_reg     <= p_wb_vld;
            wb_key_reg     <= rq_key;
            wb_val_reg     <= rq_val;
            res_status_reg <= p_status;
            res_found_reg  <= p_found;
            res_slot_reg   <= p_slot;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_found_value = out_found_reg;
    assign out_slot        = out_slot_reg;

endmodule

/* sv/lpht_checker.sv */
module lpht_checker #(
    parameter int TABLE_SIZE = 251
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [31:0] rsp_found_value,
    input logic [7:0]  rsp_slot
);
    import lpht_pkg::*;

    // one request in flight: ready drops right after an accepted beat
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one in work");

    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STATUS_OK |-> rsp_found_value == 32'd0)
        else $error("found_value nonzero on failed request");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (TABLE_SIZE > 256) || (32'(rsp_slot) < 32'(TABLE_SIZE)))
        else $error("slot outside table");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_found_value) && $stable(rsp_slot))
        else $error("stalled result beat changed");

endmodule

bind linear_probe_hash_table lpht_checker #(.TABLE_SIZE(TABLE_SIZE)) u_lpht_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_found_value (rsp.found_value),
    .rsp_slot        (rsp.slot)
);
